// File: hw/rtl/cio_pkg.sv
// Shared types, codes and constant tables of the console I/O and IRQ controller.
package cio_pkg;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Port addresses (low byte)
  localparam logic [7:0] PORT_TONE_A = 8'hF8;
  localparam logic [7:0] PORT_TONE_C = 8'hFA;
  localparam logic [7:0] PORT_VOLUME = 8'hFB;
  localparam logic [7:0] PORT_STATUS = 8'hFC;
  localparam logic [7:0] PORT_MATRIX = 8'hFD;
  localparam logic [7:0] PORT_VBASE  = 8'hFE;
  localparam logic [7:0] PORT_VCTRL  = 8'hFF;

  // Line timing
  localparam logic [8:0] FRAME_LINES    = 9'd262;
  localparam logic [8:0] LINE_ACTIVE    = 9'd192;
  localparam logic [8:0] LINE_IRQ_FIRST = 9'd195;
  localparam logic [8:0] LINE_IRQ_LAST  = 9'd251;
  localparam logic [8:0] LINE_IRQ_FULL  = 9'd255;
  localparam logic [7:0] BUDGET_LONG    = 8'd230;
  localparam logic [7:0] BUDGET_SHORT   = 8'd32;

  // Read constants
  localparam logic [7:0] READ_BASE     = 8'h80;
  localparam logic [7:0] READ_UNMAPPED = 8'hFF;

  // Reset value of the tile map base
  localparam logic [5:0] VBASE_RESET = 6'h2E;

  // Sound write beats: three command bytes
  localparam logic [1:0] BEAT_FIRST = 2'd0;
  localparam logic [1:0] BEAT_HIGH  = 2'd1;
  localparam logic [1:0] BEAT_LAST  = 2'd2;

  // Tone divider table, indexed by the inverted 6-bit divider
  localparam logic [9:0] TONE_MAP [64] = '{
    10'd0,   10'd13,  10'd26,  10'd38,  10'd51,  10'd64,  10'd77,  10'd90,
    10'd102, 10'd115, 10'd128, 10'd141, 10'd154, 10'd166, 10'd179, 10'd192,
    10'd205, 10'd218, 10'd230, 10'd243, 10'd256, 10'd269, 10'd282, 10'd294,
    10'd307, 10'd320, 10'd333, 10'd346, 10'd358, 10'd371, 10'd384, 10'd397,
    10'd410, 10'd422, 10'd435, 10'd448, 10'd461, 10'd474, 10'd486, 10'd499,
    10'd512, 10'd525, 10'd538, 10'd550, 10'd563, 10'd576, 10'd589, 10'd602,
    10'd614, 10'd627, 10'd640, 10'd653, 10'd666, 10'd678, 10'd691, 10'd704,
    10'd717, 10'd730, 10'd743, 10'd755, 10'd768, 10'd781, 10'd794, 10'd807
  };

  // One input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  port;
    logic [7:0]  data;
    logic [15:0] pad_state;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic       irq_clear;
    logic       frame_end;
    logic [7:0] cycle_budget;
    logic [7:0] sound_byte;
    logic       sound_valid;
    logic       last;
    logic [5:0] video_base;
    logic [2:0] pattern_base;
    logic [4:0] video_flags;
  } result_t;

  // Tone latch command for a channel
  function automatic logic [7:0] latch_code(input logic [1:0] ch);
    logic [7:0] code;
    unique case (ch)
      2'd0:    code = 8'h80;
      2'd1:    code = 8'hA0;
      default: code = 8'hC0;
    endcase
    return code;
  endfunction

  // Volume command for a channel: its level when on, silence otherwise
  function automatic logic [7:0] vol_byte(input logic [1:0] ch, input logic on);
    logic [7:0] code;
    logic [3:0] lvl;
    unique case (ch)
      2'd0:    begin code = 8'h90; lvl = 4'h9; end
      2'd1:    begin code = 8'hB0; lvl = 4'h7; end
      default: begin code = 8'hD0; lvl = 4'h5; end
    endcase
    return code | {4'h0, (on ? lvl : 4'hF)};
  endfunction

endpackage

// File: hw/rtl/cio_regs.sv
// Controller state and the single-pass decode of one beat into one result.
module cio_regs import cio_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic [1:0] beat,
  input  logic    commit,
  output result_t res
);

  logic [8:0] line_count, line_count_next;
  logic [7:0] irq_status, irq_status_next;
  logic [7:0] irq_enable, irq_enable_next;
  logic [7:0] scan_columns, scan_columns_next;
  logic [2:0] tone_on, tone_on_next;
  logic [5:0] video_base_reg, video_base_reg_next;
  logic [2:0] pattern_base_reg, pattern_base_reg_next;
  logic [4:0] video_flag_reg, video_flag_reg_next;

  logic [7:0] p1, p2;
  logic [3:0] mtx;
  logic [9:0] tone_f;
  logic       is_tone, is_vol;
  logic [1:0] snd_ch;
  logic       snd_on;
  logic [8:0] ln;

  // Joystick matrix for the selected columns: P1 in bits 1:0, P2 in 3:2
  always_comb begin
    p1  = item.pad_state[7:0];
    p2  = item.pad_state[15:8];
    mtx = '0;
    if (scan_columns[0]) begin
      mtx = mtx | {item.pad_state == 16'h0200, item.pad_state == 16'h0100,
                   item.pad_state == 16'h0002, item.pad_state == 16'h0001};
    end
    if (scan_columns[1]) mtx = mtx | {p2[3], p2[2], p1[3], p1[2]};
    if (scan_columns[2]) mtx = mtx | {p2[5], p2[4], p1[5], p1[4]};
    if (scan_columns[3]) mtx = mtx | {p2[7], p2[6], p1[7], p1[6]};
  end

  // Sound command decode
  assign tone_f  = TONE_MAP[~item.data[5:0]];
  assign is_tone = (item.port >= PORT_TONE_A) && (item.port <= PORT_TONE_C);
  assign is_vol  = (item.port == PORT_VOLUME);
  assign snd_ch  = is_tone ? (item.port[1:0] - PORT_TONE_A[1:0]) : beat;
  assign snd_on  = is_tone ? (tone_f != '0) : (item.data[1] && tone_on[snd_ch]);
  assign ln      = line_count + 9'd1;

  // Work out the result and the next state
  always_comb begin
    line_count_next       = line_count;
    irq_status_next       = irq_status;
    irq_enable_next       = irq_enable;
    scan_columns_next     = scan_columns;
    tone_on_next          = tone_on;
    video_base_reg_next   = video_base_reg;
    pattern_base_reg_next = pattern_base_reg;
    video_flag_reg_next   = video_flag_reg;
    res                   = '0;
    res.last              = 1'b1;

    unique case (op_t'(item.operation))
      OP_READ: begin
        if (item.port == PORT_STATUS) begin
          res.read_data = irq_status | READ_BASE | {4'h0, mtx[3:2], 2'b00};
        end else if (item.port == PORT_MATRIX) begin
          res.read_data = READ_BASE | {4'h0, mtx};
          if (irq_status[1]) begin
            irq_status_next[1] = 1'b0;
            res.irq_clear      = 1'b1;
          end
        end else begin
          res.read_data = READ_UNMAPPED;
        end
      end
      OP_WRITE: begin
        if (is_tone || is_vol) begin
          res.sound_valid = 1'b1;
          res.last        = (beat == BEAT_LAST);
          if (is_tone && beat == BEAT_FIRST) begin
            res.sound_byte = latch_code(snd_ch) | {4'h0, tone_f[3:0]};
          end else if (is_tone && beat == BEAT_HIGH) begin
            res.sound_byte = {2'b00, tone_f[9:4]};
          end else begin
            res.sound_byte = vol_byte(snd_ch, snd_on);
          end
          if (is_tone) tone_on_next[snd_ch] = (tone_f != '0);
        end else if (item.port == PORT_STATUS) begin
          irq_enable_next = item.data;
        end else if (item.port == PORT_MATRIX) begin
          scan_columns_next = item.data;
          if (irq_status[0]) begin
            irq_status_next[0] = 1'b0;
            res.irq_clear      = 1'b1;
          end
        end else if (item.port == PORT_VBASE) begin
          video_base_reg_next = item.data[7:2];
        end else if (item.port == PORT_VCTRL) begin
          pattern_base_reg_next = item.data[7:5];
          video_flag_reg_next   = item.data[4:0];
        end
      end
      OP_TICK: begin
        res.cycle_budget = (line_count >= LINE_ACTIVE || video_flag_reg[3]) ?
                           BUDGET_LONG : BUDGET_SHORT;
        if (ln >= LINE_IRQ_FIRST && ln <= LINE_IRQ_LAST && ln[1:0] == 2'b11) begin
          if (irq_enable[1]) begin
            res.irq_raise      = 1'b1;
            irq_status_next[1] = 1'b1;
          end
        end else if (ln == LINE_IRQ_FULL) begin
          if (irq_enable[1:0] != 2'b00) begin
            res.irq_raise   = 1'b1;
            irq_status_next = irq_enable;
          end
        end
        if (ln == FRAME_LINES) begin
          line_count_next = '0;
          res.frame_end   = 1'b1;
        end else begin
          line_count_next = ln;
        end
      end
      OP_NONE: begin
        res.last = 1'b1;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase

    res.video_base   = video_base_reg_next;
    res.pattern_base = pattern_base_reg_next;
    res.video_flags  = video_flag_reg_next;
  end

  // Update state when the last beat of an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count       <= '0;
      irq_status       <= '0;
      irq_enable       <= '0;
      scan_columns     <= '0;
      tone_on          <= '0;
      video_base_reg   <= VBASE_RESET;
      pattern_base_reg <= '0;
      video_flag_reg   <= '0;
    end else if (commit) begin
      line_count       <= line_count_next;
      irq_status       <= irq_status_next;
      irq_enable       <= irq_enable_next;
      scan_columns     <= scan_columns_next;
      tone_on          <= tone_on_next;
      video_base_reg   <= video_base_reg_next;
      pattern_base_reg <= pattern_base_reg_next;
      video_flag_reg   <= video_flag_reg_next;
    end
  end

endmodule

// File: hw/rtl/console_io_irq_controller.sv
// Top level of the console I/O and IRQ controller: input register, decode, result register.
// Each accepted bus read, bus write or scanline tick is held in an input register, decoded in
// one pass against the controller state and written to a result register, where it stays on
// the output until it is taken. Reads, non-sound writes and ticks give one result each, so a
// new beat can be accepted every cycle while the result register is not stalled. Writes to
// the tone ports and the volume port emit three sound command bytes and hold the input
// register until the last byte is written to the result register. The result register only
// stalls the input side when out_ready is low and a result is waiting.
module console_io_irq_controller import cio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  port,
  input  logic [7:0]  data,
  input  logic [15:0] pad_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        irq_raise,
  output logic        irq_clear,
  output logic        frame_end,
  output logic [7:0]  cycle_budget,
  output logic [7:0]  sound_byte,
  output logic        sound_valid,
  output logic        last,
  output logic [5:0]  video_base,
  output logic [2:0]  pattern_base,
  output logic [4:0]  video_flags
);

  logic       hold_valid;
  item_t      hold;
  logic [1:0] beat;
  result_t    res;
  result_t    out_reg;
  logic       out_load;
  logic       fire;

  // Result register takes a new beat when empty or being drained
  assign out_load = !out_valid || out_ready;
  assign fire     = hold_valid && out_load;
  assign in_ready = !hold_valid || (fire && res.last);

  cio_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .item   (hold),
    .beat   (beat),
    .commit (fire && res.last),
    .res    (res)
  );

  // Input register and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      beat       <= BEAT_FIRST;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (fire) beat <= res.last ? BEAT_FIRST : beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= '{operation: operation, port: port, data: data, pad_state: pad_state};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_reg <= res;
  end

  assign read_data    = out_reg.read_data;
  assign irq_raise    = out_reg.irq_raise;
  assign irq_clear    = out_reg.irq_clear;
  assign frame_end    = out_reg.frame_end;
  assign cycle_budget = out_reg.cycle_budget;
  assign sound_byte   = out_reg.sound_byte;
  assign sound_valid  = out_reg.sound_valid;
  assign last         = out_reg.last;
  assign video_base   = out_reg.video_base;
  assign pattern_base = out_reg.pattern_base;
  assign video_flags  = out_reg.video_flags;

endmodule

// File: hw/rtl/cio_checker.sv
// Port-level checks of the console I/O and IRQ controller, bound to the top level.
module cio_checker import cio_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic [7:0]  port,
  input logic [7:0]  data,
  input logic [15:0] pad_state,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic        irq_raise,
  input logic        irq_clear,
  input logic        frame_end,
  input logic [7:0]  cycle_budget,
  input logic [7:0]  sound_byte,
  input logic        sound_valid,
  input logic        last,
  input logic [5:0]  video_base,
  input logic [2:0]  pattern_base,
  input logic [4:0]  video_flags
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sound_byte) && $stable(read_data)
                                && $stable(last))
    else $error("stalled result changed");

  // Sound bytes of one write follow back to back
  a_sound_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && sound_valid && !last |=> out_valid && sound_valid)
    else $error("sound burst broken");

  // Budget is zero, short or long
  a_budget: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cycle_budget == 8'd0 || cycle_budget == BUDGET_SHORT ||
                   cycle_budget == BUDGET_LONG))
    else $error("bad cycle budget");

  // Frame end and IRQ raise only happen on long lines
  a_tick_events: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_end || irq_raise) |-> cycle_budget == BUDGET_LONG && !sound_valid)
    else $error("tick event on a non-tick result");

endmodule

bind console_io_irq_controller cio_checker u_cio_checker (.*);
